// ----- sv/nsaf_pkg.sv -----
// Shared types and constants for the icon downscale and alpha flatten block.
`timescale 1ns / 1ps
package nsaf_pkg;

  localparam int REG_IDX_W = 2;
  localparam int REG_DATA_W = 9;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_LAST = 2'd2;

  localparam logic [REG_DATA_W-1:0] SRC_WIDTH_RESET = 9'd20;
  localparam logic [REG_DATA_W-1:0] SRC_HEIGHT_RESET = 9'd20;

  localparam logic [7:0] GREY = 8'd192;
  localparam logic [7:0] ALPHA_MAX = 8'd255;

  localparam int CHAN_W = 8;
  localparam int RECT_W = 5;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } argb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [RECT_W-1:0] col_first;
    logic [RECT_W-1:0] col_count;
    logic [RECT_W-1:0] row_first;
    logic [RECT_W-1:0] row_count;
    logic last;
  } result_t;

endpackage

// ----- sv/nsaf_fifo.sv -----
// Register-based first-in first-out queue with show-ahead read.
`timescale 1ns / 1ps
module nsaf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;
  logic [CW-1:0] count_next;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- sv/nsaf_front.sv -----
// Front end: takes source pixels, tracks raster position, orders the bytes.
`timescale 1ns / 1ps
module nsaf_front
  import nsaf_pkg::*;
#(
  parameter int MAX_SRC = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               queue_full,
  input  logic [CHAN_W-1:0]                  byte_zero,
  input  logic [CHAN_W-1:0]                  byte_one,
  input  logic [CHAN_W-1:0]                  byte_two,
  input  logic [CHAN_W-1:0]                  byte_three,
  input  logic                               alpha_last,
  input  logic [$clog2(MAX_SRC+1)-1:0]       size_w,
  input  logic [$clog2(MAX_SRC+1)-1:0]       size_h,
  output logic                               accept,
  output logic [$clog2(MAX_SRC)-1:0]         pos_col,
  output logic [$clog2(MAX_SRC)-1:0]         pos_row,
  output argb_t                              pix
);

  localparam int PW = $clog2(MAX_SRC);

  logic [PW-1:0] col;
  logic [PW-1:0] row;
  logic [PW-1:0] col_next;
  logic [PW-1:0] row_next;
  logic [PW:0] col_inc;
  logic [PW:0] row_inc;

  assign accept = push && !queue_full;
  assign pos_col = col;
  assign pos_row = row;

  always_comb begin
    if (alpha_last) begin
      pix = '{a: byte_three, r: byte_two, g: byte_one, b: byte_zero};
    end else begin
      pix = '{a: byte_zero, r: byte_one, g: byte_two, b: byte_three};
    end
  end

  // Wrap column at the width, row at the height.
  always_comb begin
    col_inc = {1'b0, col} + (PW+1)'(1);
    row_inc = {1'b0, row} + (PW+1)'(1);
    col_next = col;
    row_next = row;
    if (accept) begin
      if (col_inc >= (PW+1)'(size_w)) begin
        col_next = '0;
        row_next = (row_inc >= (PW+1)'(size_h)) ? '0 : row_inc[PW-1:0];
      end else begin
        col_next = col_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// ----- sv/nsaf_back.sv -----
// Back end: span dividers and alpha blend pipeline with output credit.
`timescale 1ns / 1ps
module nsaf_back
  import nsaf_pkg::*;
#(
  parameter int OUT_SIZE = 20,
  parameter int MAX_SRC = 256,
  parameter int RES_DEPTH = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_pop,
  input  logic [$clog2(MAX_SRC)-1:0]         pos_col,
  input  logic [$clog2(MAX_SRC)-1:0]         pos_row,
  input  argb_t                              pix,
  input  logic [$clog2(MAX_SRC+1)-1:0]       size_w,
  input  logic [$clog2(MAX_SRC+1)-1:0]       size_h,
  input  logic [$clog2(RES_DEPTH+1)-1:0]     res_count,
  output logic                               res_valid,
  output result_t                            res
);

  localparam int QW = $clog2(OUT_SIZE + 1);
  localparam int NUMW = $clog2(MAX_SRC * (OUT_SIZE + 1));
  localparam int CW = NUMW + QW;
  localparam int PD = QW + 2;
  localparam int TW = $clog2(RES_DEPTH + PD + 1);
  localparam int LANES = 4;
  localparam int PROD_W = 2 * CHAN_W;

  // Lanes: column low, column high, row low, row high.
  logic va;
  logic [NUMW-1:0] num_a [LANES];
  logic [PROD_W-1:0] prod_a [3];

  logic vs [QW+1];
  logic [CW-1:0] rem [QW+1][LANES];
  logic [QW-1:0] quo [QW+1][LANES];
  logic sat [QW+1][LANES];
  logic [CHAN_W-1:0] chan [QW+1][3];

  logic [CW-1:0] step_rem [QW][LANES];
  logic step_bit [QW][LANES];

  logic [TW-1:0] inflight;
  logic [CW-1:0] w_ext;
  logic [CW-1:0] h_ext;
  logic [QW-1:0] bound [LANES];
  logic [QW-1:0] col_cnt;
  logic [QW-1:0] row_cnt;
  logic [CHAN_W-1:0] ch_in [3];
  logic [PROD_W:0] blend_sum [3];

  assign w_ext = CW'(size_w);
  assign h_ext = CW'(size_h);

  always_comb begin
    inflight = TW'(va);
    for (int s = 0; s <= QW; s++) begin
      inflight = inflight + TW'(vs[s]);
    end
  end

  assign in_pop = in_valid && ((TW'(res_count) + inflight) < TW'(RES_DEPTH));

  assign ch_in[0] = pix.r;
  assign ch_in[1] = pix.g;
  assign ch_in[2] = pix.b;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend_sum[c] = (PROD_W+1)'(prod_a[c]) + (PROD_W+1)'(prod_a[c] >> CHAN_W)
                     + (PROD_W+1)'(1);
    end
  end

  // One restoring quotient bit per stage, most significant first.
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < LANES; l++) begin
        logic [CW-1:0] dvs;
        dvs = ((l < 2) ? w_ext : h_ext) << (QW - 1 - j);
        step_bit[j][l] = (rem[j][l] >= dvs);
        step_rem[j][l] = step_bit[j][l] ? rem[j][l] - dvs : rem[j][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        vs[s] <= 1'b0;
      end
    end else begin
      va <= in_pop;
      vs[0] <= va;
      for (int s = 0; s < QW; s++) begin
        vs[s+1] <= vs[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    num_a[0] <= NUMW'(pos_col) * NUMW'(OUT_SIZE) + NUMW'(size_w) - NUMW'(1);
    num_a[1] <= (NUMW'(pos_col) + NUMW'(1)) * NUMW'(OUT_SIZE) + NUMW'(size_w) - NUMW'(1);
    num_a[2] <= NUMW'(pos_row) * NUMW'(OUT_SIZE) + NUMW'(size_h) - NUMW'(1);
    num_a[3] <= (NUMW'(pos_row) + NUMW'(1)) * NUMW'(OUT_SIZE) + NUMW'(size_h) - NUMW'(1);
    for (int c = 0; c < 3; c++) begin
      prod_a[c] <= PROD_W'(ch_in[c]) * PROD_W'(pix.a)
                   + PROD_W'(GREY) * PROD_W'(ALPHA_MAX - pix.a);
    end

    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= CW'(num_a[l]);
      quo[0][l] <= '0;
      sat[0][l] <= CW'(num_a[l]) >= (((l < 2) ? w_ext : h_ext) << QW);
    end
    for (int c = 0; c < 3; c++) begin
      chan[0][c] <= CHAN_W'(blend_sum[c] >> CHAN_W);
    end

    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < LANES; l++) begin
        rem[j+1][l] <= step_rem[j][l];
        quo[j+1][l] <= quo[j][l] | (QW'(step_bit[j][l]) << (QW - 1 - j));
        sat[j+1][l] <= sat[j][l];
      end
      for (int c = 0; c < 3; c++) begin
        chan[j+1][c] <= chan[j][c];
      end
    end
  end

  // Clamp span ends to the output size and form the rectangle.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (sat[QW][l] || (quo[QW][l] > QW'(OUT_SIZE))) begin
        bound[l] = QW'(OUT_SIZE);
      end else begin
        bound[l] = quo[QW][l];
      end
    end
    col_cnt = (bound[1] > bound[0]) ? bound[1] - bound[0] : '0;
    row_cnt = (bound[3] > bound[2]) ? bound[3] - bound[2] : '0;
    res_valid = vs[QW] && (col_cnt != '0) && (row_cnt != '0);
    res.red = chan[QW][0];
    res.green = chan[QW][1];
    res.blue = chan[QW][2];
    res.col_first = RECT_W'(bound[0]);
    res.col_count = RECT_W'(col_cnt);
    res.row_first = RECT_W'(bound[2]);
    res.row_count = RECT_W'(row_cnt);
    res.last = (bound[1] == QW'(OUT_SIZE)) && (bound[3] == QW'(OUT_SIZE));
  end

endmodule

// ----- sv/nearest_scale_alpha_flatten_core.sv -----
// Top level: icon downscaler with alpha flatten over grey.
`timescale 1ns / 1ps
// Takes one source pixel per cycle in raster order while full is low and, for
// each pixel picked by the OUT_SIZE x OUT_SIZE nearest-neighbor grid, returns one
// item holding the color blended over grey 192 and the output rectangle it
// covers. Sustained rate is one item per cycle on both sides while results are
// popped as they show. Each span is found by pipelined restoring dividers, one
// quotient bit per stage. Pixels that cover no output pixel leave no result.
// Write the size and byte order registers only while the block is idle; no
// clearing pass follows reset.
module nearest_scale_alpha_flatten_core
  import nsaf_pkg::*;
#(
  parameter int OUT_SIZE = 20,
  parameter int MAX_SRC = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [CHAN_W-1:0]      byte_zero,
  input  logic [CHAN_W-1:0]      byte_one,
  input  logic [CHAN_W-1:0]      byte_two,
  input  logic [CHAN_W-1:0]      byte_three,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAN_W-1:0]      red,
  output logic [CHAN_W-1:0]      green,
  output logic [CHAN_W-1:0]      blue,
  output logic [RECT_W-1:0]      col_first,
  output logic [RECT_W-1:0]      col_count,
  output logic [RECT_W-1:0]      row_first,
  output logic [RECT_W-1:0]      row_count,
  output logic                   last,
  input  logic                   wr_en,
  input  logic [REG_IDX_W-1:0]   wr_index,
  input  logic [REG_DATA_W-1:0]  wr_data
);

  localparam int PW = $clog2(MAX_SRC);
  localparam int SZW = $clog2(MAX_SRC + 1);
  localparam int QW = $clog2(OUT_SIZE + 1);
  localparam int PIPE_DEPTH = QW + 2;
  localparam int RES_DEPTH = PIPE_DEPTH + 2;
  localparam int MID_DEPTH = 2;
  localparam int MID_W = 2 * PW + $bits(argb_t);

  logic [REG_DATA_W-1:0] src_width;
  logic [REG_DATA_W-1:0] src_height;
  logic alpha_last;
  logic [SZW-1:0] size_w;
  logic [SZW-1:0] size_h;

  logic front_accept;
  logic [PW-1:0] front_col;
  logic [PW-1:0] front_row;
  argb_t front_pix;

  logic [MID_W-1:0] mid_wdata;
  logic [MID_W-1:0] mid_rdata;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  logic [PW-1:0] back_col;
  logic [PW-1:0] back_row;
  argb_t back_pix;

  logic res_push;
  result_t res_in;
  result_t res_out;
  logic res_full;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= SRC_WIDTH_RESET;
      src_height <= SRC_HEIGHT_RESET;
      alpha_last <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SRC_WIDTH: src_width <= wr_data;
        REG_SRC_HEIGHT: src_height <= wr_data;
        REG_ALPHA_LAST: alpha_last <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Treat zero as one and clip to the largest supported source.
  always_comb begin
    if (src_width == '0) begin
      size_w = SZW'(1);
    end else if (32'(src_width) > MAX_SRC) begin
      size_w = SZW'(MAX_SRC);
    end else begin
      size_w = SZW'(src_width);
    end
    if (src_height == '0) begin
      size_h = SZW'(1);
    end else if (32'(src_height) > MAX_SRC) begin
      size_h = SZW'(MAX_SRC);
    end else begin
      size_h = SZW'(src_height);
    end
  end

  nsaf_front #(
    .MAX_SRC(MAX_SRC)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .queue_full(mid_full),
    .byte_zero(byte_zero),
    .byte_one(byte_one),
    .byte_two(byte_two),
    .byte_three(byte_three),
    .alpha_last(alpha_last),
    .size_w(size_w),
    .size_h(size_h),
    .accept(front_accept),
    .pos_col(front_col),
    .pos_row(front_row),
    .pix(front_pix)
  );

  assign full = mid_full;
  assign mid_wdata = {front_col, front_row, front_pix};
  assign {back_col, back_row, back_pix} = mid_rdata;

  nsaf_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk(clk),
    .rst(rst),
    .push(front_accept),
    .wdata(mid_wdata),
    .full(mid_full),
    .pop(mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty),
    .count()
  );

  nsaf_back #(
    .OUT_SIZE(OUT_SIZE),
    .MAX_SRC(MAX_SRC),
    .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(!mid_empty),
    .in_pop(mid_pop),
    .pos_col(back_col),
    .pos_row(back_row),
    .pix(back_pix),
    .size_w(size_w),
    .size_h(size_h),
    .res_count(res_count),
    .res_valid(res_push),
    .res(res_in)
  );

  nsaf_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res_in),
    .full(res_full),
    .pop(pop),
    .rdata(res_out),
    .empty(empty),
    .count(res_count)
  );

  assign red = res_out.red;
  assign green = res_out.green;
  assign blue = res_out.blue;
  assign col_first = res_out.col_first;
  assign col_count = res_out.col_count;
  assign row_first = res_out.row_first;
  assign row_count = res_out.row_count;
  assign last = res_out.last;

`ifndef ASSERT_OFF
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_mid_pop_valid: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("back end issued from empty queue");

  a_res_shows: assert property (@(posedge clk) disable iff (rst)
    (res_push && empty) |=> !empty)
    else $error("result written but not shown");
`endif

endmodule
